/* rtl/core/matrix3_inverse_adjugate_top_assert.svh */
// Assertion macros for the 3x3 inverse block and its checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef MATRIX3_INVERSE_ADJUGATE_TOP_ASSERT_SVH
`define MATRIX3_INVERSE_ADJUGATE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define M3I_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("m3i: same-cycle check failed");

// Next-cycle implication, ignored while in reset.
`define M3I_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("m3i: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define M3I_CHK_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("m3i: reset check failed");

`endif

/* rtl/core/m3i_pkg.sv */
`timescale 1ns / 1ps
package m3i_pkg;
  localparam int EW = 32;
  localparam int FB = 16;
  localparam int SH = 2 * FB;
  localparam int PW = 2 * EW;
  localparam int CW = PW + 1;
  localparam int HW = CW - EW;
  localparam int MW = EW + HW;
  localparam int DW = EW + CW + 2;
  localparam int QB = EW + 1;
  localparam int RW = DW + QB;
  localparam int NS = 9;

  // Operand indexes of the two products behind each cofactor
  localparam int IDX_A [NS] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
  localparam int IDX_B [NS] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
  localparam int IDX_C [NS] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
  localparam int IDX_D [NS] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};
  // Cofactors with odd row plus column flip sign
  localparam logic [NS-1:0] NEG_COF = 9'h0AA;
  // Source cofactor of each adjugate entry
  localparam int TRN [NS] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

  localparam logic [EW-1:0] ENT_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic [EW-1:0] ENT_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [QB-1:0] LIM_POS = {2'b00, {(EW-1){1'b1}}};
  localparam logic [QB-1:0] LIM_NEG = {2'b01, {(EW-1){1'b0}}};

  typedef logic [NS-1:0][EW-1:0] mat_t;
  typedef logic [RW-1:0] rem_t;
  typedef logic [QB-1:0] quo_t;

  typedef struct packed {
    rem_t dsh;
    rem_t [NS-1:0] r;
    quo_t [NS-1:0] q;
    logic [NS-1:0] neg;
    logic [NS-1:0] ovf;
    logic sing;
  } div_t;

  typedef struct packed {
    mat_t m;
    logic sing;
    logic ovf;
  } res_t;
endpackage

/* rtl/core/m3i_ifs.sv */
`timescale 1ns / 1ps
interface m3i_in_if;
  logic valid;
  logic ready;
  logic signed [m3i_pkg::EW-1:0] in_r0c0, in_r0c1, in_r0c2;
  logic signed [m3i_pkg::EW-1:0] in_r1c0, in_r1c1, in_r1c2;
  logic signed [m3i_pkg::EW-1:0] in_r2c0, in_r2c1, in_r2c2;
  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3i_out_if;
  logic valid;
  logic ready;
  logic signed [m3i_pkg::EW-1:0] out_r0c0, out_r0c1, out_r0c2;
  logic signed [m3i_pkg::EW-1:0] out_r1c0, out_r1c1, out_r1c2;
  logic signed [m3i_pkg::EW-1:0] out_r2c0, out_r2c1, out_r2c2;
  logic singular;
  logic overflow;
  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                  out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, overflow,
                  input ready);
  modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, overflow,
                output ready);
endinterface

/* rtl/core/m3i_front.sv */
`timescale 1ns / 1ps
module m3i_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_up,
  output logic               ready_up,
  input  m3i_pkg::mat_t      mat,
  output logic               valid_dn,
  input  logic               ready_dn,
  output m3i_pkg::div_t      dout
);
  localparam int NST = 7;

  logic [NST-1:0] v;
  logic [NST:0]   en;

  logic signed [m3i_pkg::PW-1:0] pa [m3i_pkg::NS];
  logic signed [m3i_pkg::PW-1:0] pb [m3i_pkg::NS];
  logic [2:0][m3i_pkg::EW-1:0]   row1;
  logic [2:0][m3i_pkg::EW-1:0]   row2;
  logic signed [m3i_pkg::CW-1:0] cof2 [m3i_pkg::NS];
  logic signed [m3i_pkg::CW-1:0] cof3 [m3i_pkg::NS];
  logic signed [m3i_pkg::CW-1:0] cof4 [m3i_pkg::NS];
  logic signed [m3i_pkg::CW-1:0] cof5 [m3i_pkg::NS];
  logic signed [m3i_pkg::MW-1:0] lo3 [3];
  logic signed [m3i_pkg::MW-1:0] hi3 [3];
  logic signed [m3i_pkg::DW-1:0] term4 [3];
  logic signed [m3i_pkg::DW-1:0] det5;
  logic [m3i_pkg::DW-1:0]        dabs6;
  logic [m3i_pkg::CW-1:0]        cabs6 [m3i_pkg::NS];
  logic [m3i_pkg::NS-1:0]        neg6;
  logic                          sing6;

  logic signed [m3i_pkg::CW-1:0] diff [m3i_pkg::NS];
  logic signed [m3i_pkg::CW-1:0] cofn [m3i_pkg::NS];
  logic signed [m3i_pkg::DW-1:0] tsum [3];
  m3i_pkg::div_t                 d7;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NST] = ready_dn;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign ready_up = en[0];
  assign valid_dn = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= valid_up;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Form the cofactor differences with their checkerboard sign
  always_comb begin
    for (int f = 0; f < m3i_pkg::NS; f++) begin
      diff[f] = {pa[f][m3i_pkg::PW-1], pa[f]} - {pb[f][m3i_pkg::PW-1], pb[f]};
      cofn[f] = m3i_pkg::NEG_COF[f] ? -diff[f] : diff[f];
    end
  end

  // Rebuild each determinant term from its split partial products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tsum[j] = ({{(m3i_pkg::DW-m3i_pkg::MW){hi3[j][m3i_pkg::MW-1]}}, hi3[j]}
                 <<< m3i_pkg::EW)
              + {{(m3i_pkg::DW-m3i_pkg::MW){lo3[j][m3i_pkg::MW-1]}}, lo3[j]};
    end
  end

  // Scale numerators and precheck for quotients beyond the working range
  always_comb begin
    d7.dsh  = m3i_pkg::RW'(dabs6) << m3i_pkg::QB;
    d7.neg  = neg6;
    d7.sing = sing6;
    for (int k = 0; k < m3i_pkg::NS; k++) begin
      d7.r[k]   = m3i_pkg::RW'(cabs6[k]) << m3i_pkg::SH;
      d7.q[k]   = '0;
      d7.ovf[k] = (m3i_pkg::RW'(cabs6[k]) << m3i_pkg::SH) >= d7.dsh;
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: pairwise products
    if (en[0]) begin
      for (int f = 0; f < m3i_pkg::NS; f++) begin
        pa[f] <= $signed(mat[m3i_pkg::IDX_A[f]]) * $signed(mat[m3i_pkg::IDX_B[f]]);
        pb[f] <= $signed(mat[m3i_pkg::IDX_C[f]]) * $signed(mat[m3i_pkg::IDX_D[f]]);
      end
      row1 <= mat[2:0];
    end
    // Stage 2: cofactors
    if (en[1]) begin
      cof2 <= cofn;
      row2 <= row1;
    end
    // Stage 3: row 0 times cofactors, split into low and high halves
    if (en[2]) begin
      cof3 <= cof2;
      for (int j = 0; j < 3; j++) begin
        lo3[j] <= $signed(row2[j]) * $signed({1'b0, cof2[j][m3i_pkg::EW-1:0]});
        hi3[j] <= $signed(row2[j]) * $signed(cof2[j][m3i_pkg::CW-1:m3i_pkg::EW]);
      end
    end
    // Stage 4: full determinant terms
    if (en[3]) begin
      cof4  <= cof3;
      term4 <= tsum;
    end
    // Stage 5: determinant
    if (en[4]) begin
      cof5 <= cof4;
      det5 <= term4[0] + term4[1] + term4[2];
    end
    // Stage 6: magnitudes and quotient signs, adjugate order
    if (en[5]) begin
      dabs6 <= det5[m3i_pkg::DW-1] ? -det5 : det5;
      sing6 <= (det5 == '0);
      for (int k = 0; k < m3i_pkg::NS; k++) begin
        cabs6[k] <= cof5[m3i_pkg::TRN[k]][m3i_pkg::CW-1] ?
                    -cof5[m3i_pkg::TRN[k]] : cof5[m3i_pkg::TRN[k]];
        neg6[k]  <= cof5[m3i_pkg::TRN[k]][m3i_pkg::CW-1] ^ det5[m3i_pkg::DW-1];
      end
    end
    // Stage 7: divider setup
    if (en[6]) begin
      dout <= d7;
    end
  end
endmodule

/* rtl/core/m3i_div_step.sv */
`timescale 1ns / 1ps
module m3i_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_up,
  output logic          ready_up,
  input  m3i_pkg::div_t din,
  output logic          valid_dn,
  input  logic          ready_dn,
  output m3i_pkg::div_t dout
);
  logic          v;
  m3i_pkg::div_t nxt;
  logic          ge;

  assign ready_up = !v || ready_dn;
  assign valid_dn = v;

  // One restoring step per lane against the shared shifted divisor
  always_comb begin
    ge       = 1'b0;
    nxt      = din;
    nxt.dsh  = din.dsh >> 1;
    for (int k = 0; k < m3i_pkg::NS; k++) begin
      ge        = din.r[k] >= nxt.dsh;
      nxt.r[k]  = ge ? din.r[k] - nxt.dsh : din.r[k];
      nxt.q[k]  = {din.q[k][m3i_pkg::QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ready_up) begin
      v <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      dout <= nxt;
    end
  end
endmodule

/* rtl/core/m3i_back.sv */
`timescale 1ns / 1ps
module m3i_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_up,
  output logic          ready_up,
  input  m3i_pkg::div_t din,
  output logic          valid_dn,
  input  logic          ready_dn,
  output m3i_pkg::res_t dout
);
  logic                   v;
  m3i_pkg::res_t          nxt;
  logic [m3i_pkg::QB-1:0] lim;
  logic [m3i_pkg::QB-1:0] mag;
  logic [m3i_pkg::QB-1:0] sval;
  logic                   sat;

  assign ready_up = !v || ready_dn;
  assign valid_dn = v;

  // Saturate, apply sign, or give the error pattern when singular
  always_comb begin
    nxt  = '0;
    lim  = '0;
    mag  = '0;
    sval = '0;
    sat  = 1'b0;
    for (int k = 0; k < m3i_pkg::NS; k++) begin
      lim  = din.neg[k] ? m3i_pkg::LIM_NEG : m3i_pkg::LIM_POS;
      sat  = din.ovf[k] || (din.q[k] > lim);
      mag  = sat ? lim : din.q[k];
      sval = din.neg[k] ? -mag : mag;
      if (din.sing) begin
        nxt.m[k] = k[0] ? m3i_pkg::ENT_MAX : m3i_pkg::ENT_MIN;
      end else begin
        nxt.m[k] = sval[m3i_pkg::EW-1:0];
        nxt.ovf  = nxt.ovf | sat;
      end
    end
    nxt.sing = din.sing;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (ready_up) begin
      v <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      dout <= nxt;
    end
  end
endmodule

/* rtl/core/matrix3_inverse_adjugate_top.sv */
// 3x3 matrix inverse by exact adjugate over determinant, Q16.16 in and out.
// Pipeline: 7 cofactor/determinant stages, 33 restoring divide steps, then
// 1 output register. Every stage holds on its own when full.
// Throughput: one matrix per cycle unless the output stalls.
// Reset (synchronous, rst high) empties the pipeline; data registers keep junk.
`timescale 1ns / 1ps
module matrix3_inverse_adjugate_top (
  input  logic clk,
  input  logic rst,
  m3i_in_if.sink    in_ch,
  m3i_out_if.source out_ch
);
  m3i_pkg::mat_t mat;
  m3i_pkg::div_t dv [m3i_pkg::QB+1];
  logic          vv [m3i_pkg::QB+1];
  logic          rv [m3i_pkg::QB+1];
  m3i_pkg::res_t res;

  // Gather the request payload in row order
  assign mat[0] = in_ch.in_r0c0;
  assign mat[1] = in_ch.in_r0c1;
  assign mat[2] = in_ch.in_r0c2;
  assign mat[3] = in_ch.in_r1c0;
  assign mat[4] = in_ch.in_r1c1;
  assign mat[5] = in_ch.in_r1c2;
  assign mat[6] = in_ch.in_r2c0;
  assign mat[7] = in_ch.in_r2c1;
  assign mat[8] = in_ch.in_r2c2;

  m3i_front u_front (
    .clk      (clk),
    .rst      (rst),
    .valid_up (in_ch.valid),
    .ready_up (in_ch.ready),
    .mat      (mat),
    .valid_dn (vv[0]),
    .ready_dn (rv[0]),
    .dout     (dv[0])
  );

  // Divider: one quotient bit per stage
  for (genvar g = 0; g < m3i_pkg::QB; g++) begin : g_div
    m3i_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .valid_up (vv[g]),
      .ready_up (rv[g]),
      .din      (dv[g]),
      .valid_dn (vv[g+1]),
      .ready_dn (rv[g+1]),
      .dout     (dv[g+1])
    );
  end

  m3i_back u_back (
    .clk      (clk),
    .rst      (rst),
    .valid_up (vv[m3i_pkg::QB]),
    .ready_up (rv[m3i_pkg::QB]),
    .din      (dv[m3i_pkg::QB]),
    .valid_dn (out_ch.valid),
    .ready_dn (out_ch.ready),
    .dout     (res)
  );

  // Drive the result payload
  assign out_ch.out_r0c0 = res.m[0];
  assign out_ch.out_r0c1 = res.m[1];
  assign out_ch.out_r0c2 = res.m[2];
  assign out_ch.out_r1c0 = res.m[3];
  assign out_ch.out_r1c1 = res.m[4];
  assign out_ch.out_r1c2 = res.m[5];
  assign out_ch.out_r2c0 = res.m[6];
  assign out_ch.out_r2c1 = res.m[7];
  assign out_ch.out_r2c2 = res.m[8];
  assign out_ch.singular = res.sing;
  assign out_ch.overflow = res.ovf;
endmodule

/* rtl/core/m3i_checker.sv */
`timescale 1ns / 1ps
`include "matrix3_inverse_adjugate_top_assert.svh"
module m3i_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   singular,
  input logic                   overflow,
  input logic [m3i_pkg::EW-1:0] o00,
  input logic [m3i_pkg::EW-1:0] o01
);
  logic pat_ok;

  // Leading entries of the error pattern
  assign pat_ok = (o00 == m3i_pkg::ENT_MIN) && (o01 == m3i_pkg::ENT_MAX);

  // Pipeline stops taking requests only when full and blocked at the output
  `M3I_CHK_NOW(a_full_stall, !in_ready, out_valid && !out_ready)
  // Singular result carries the error pattern and no overflow
  `M3I_CHK_NOW(a_sing_pat, out_valid && singular, !overflow && pat_ok)
  // A blocked result stays offered
  `M3I_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // Reset empties the pipeline
  `M3I_CHK_RST(a_rst_empty, rst, !out_valid)
endmodule

bind matrix3_inverse_adjugate_top m3i_checker u_m3i_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .singular  (out_ch.singular),
  .overflow  (out_ch.overflow),
  .o00       (out_ch.out_r0c0),
  .o01       (out_ch.out_r0c1)
);

/* sim/matrix3_inverse_adjugate_top_test.sv */
`timescale 1ns / 1ps
module matrix3_inverse_adjugate_top_test;

  localparam int PIPE_LATENCY = 41;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam logic [m3i_pkg::EW-1:0] ONE_Q = 32'h0001_0000;

  typedef logic signed [127:0] wide_t;
  typedef logic [m3i_pkg::NS-1:0][m3i_pkg::EW-1:0] entries_t;

  typedef struct packed {
    entries_t e;
    logic sing;
    logic ovf;
  } inverse_t;

  typedef enum int {
    MK_FULL, MK_MODEST, MK_DIAG, MK_SINGULAR, MK_TINY
  } matrix_kind_t;

  logic clk;
  logic rst;
  m3i_in_if in_ch();
  m3i_out_if out_ch();

  matrix3_inverse_adjugate_top dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  inverse_t expected_inverses[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Exact adjugate over determinant, truncated toward zero and saturated
  function automatic inverse_t predict_inverse(entries_t a);
    wide_t m[9];
    wide_t cof[9];
    wide_t det;
    wide_t num;
    logic [127:0] q;
    logic [127:0] lim;
    logic neg;
    int r1, r2, c1, c2;
    inverse_t res;
    for (int k = 0; k < 9; k++) m[k] = wide_t'(signed'(a[k]));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        r1 = (r == 0) ? 1 : 0;
        r2 = (r == 2) ? 1 : 2;
        c1 = (c == 0) ? 1 : 0;
        c2 = (c == 2) ? 1 : 2;
        cof[r*3+c] = m[r1*3+c1] * m[r2*3+c2] - m[r1*3+c2] * m[r2*3+c1];
        if ((r + c) % 2 == 1) cof[r*3+c] = -cof[r*3+c];
      end
    end
    det = m[0] * cof[0] + m[1] * cof[1] + m[2] * cof[2];
    res.ovf = 1'b0;
    res.sing = (det == 0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (res.sing) begin
          res.e[i*3+j] = ((i*3+j) % 2 == 1) ? m3i_pkg::ENT_MAX : m3i_pkg::ENT_MIN;
        end else begin
          num = cof[j*3+i] <<< m3i_pkg::SH;
          neg = (num < 0) ^ (det < 0);
          q = ((num < 0) ? -num : num) / ((det < 0) ? -det : det);
          lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
          if (q > lim) begin
            q = lim;
            res.ovf = 1'b1;
          end
          if (neg) q = -q;
          res.e[i*3+j] = q[m3i_pkg::EW-1:0];
        end
      end
    end
    return res;
  endfunction

  function automatic logic [m3i_pkg::EW-1:0] modest_entry();
    return m3i_pkg::EW'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic entries_t make_matrix(matrix_kind_t kind);
    entries_t a;
    for (int k = 0; k < 9; k++) a[k] = modest_entry();
    case (kind)
      MK_FULL: begin
        for (int k = 0; k < 9; k++) a[k] = $urandom;
      end
      MK_DIAG: begin
        for (int k = 0; k < 9; k += 4) a[k] = (a[k] ^ 32'h0010_0000);
      end
      MK_SINGULAR: begin
        // one row is a copy or a negation of another
        a[6] = a[0]; a[7] = a[1]; a[8] = a[2];
        if ($urandom_range(1)) begin
          a[6] = -a[0]; a[7] = -a[1]; a[8] = -a[2];
        end
        if ($urandom_range(3) == 0) begin
          a[6] = $urandom; a[7] = $urandom; a[8] = $urandom;
          a[0] = a[6]; a[1] = a[7]; a[2] = a[8];
        end
      end
      MK_TINY: begin
        for (int k = 0; k < 9; k++) begin
          a[k] = m3i_pkg::EW'($signed($urandom_range(0, 16)) - 8);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always #4 clk = ~clk;

  // Offer one request and hold it until accepted, then maybe go idle
  task automatic send_matrix(entries_t a);
    in_ch.valid <= 1'b1;
    in_ch.in_r0c0 <= a[0]; in_ch.in_r0c1 <= a[1]; in_ch.in_r0c2 <= a[2];
    in_ch.in_r1c0 <= a[3]; in_ch.in_r1c1 <= a[4]; in_ch.in_r1c2 <= a[5];
    in_ch.in_r2c0 <= a[6]; in_ch.in_r2c1 <= a[7]; in_ch.in_r2c2 <= a[8];
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stop offering and wait for the pipeline to empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
  endtask

  task automatic test_directed();
    entries_t a;
    entries_t base;
    for (int k = 0; k < 9; k++) base[k] = '0;
    // identity, then a scaled diagonal with one negated entry
    a = base; a[0] = ONE_Q; a[4] = ONE_Q; a[8] = ONE_Q;
    send_matrix(a);
    a = base; a[0] = 32'h0002_0000; a[4] = 32'hFFFF_8000; a[8] = 32'h0000_4000;
    send_matrix(a);
    // zero matrix and a rank-deficient matrix are singular
    send_matrix(base);
    a = make_matrix(MK_SINGULAR);
    send_matrix(a);
    // extremes of every entry
    for (int k = 0; k < 9; k++) a[k] = m3i_pkg::ENT_MIN;
    send_matrix(a);
    for (int k = 0; k < 9; k++) a[k] = m3i_pkg::ENT_MAX;
    send_matrix(a);
    a = base; a[0] = m3i_pkg::ENT_MIN; a[4] = m3i_pkg::ENT_MIN; a[8] = m3i_pkg::ENT_MIN;
    send_matrix(a);
    a = base; a[0] = m3i_pkg::ENT_MAX; a[4] = m3i_pkg::ENT_MAX; a[8] = m3i_pkg::ENT_MAX;
    send_matrix(a);
    a = base; a[0] = m3i_pkg::ENT_MAX; a[4] = m3i_pkg::ENT_MIN; a[8] = m3i_pkg::ENT_MAX;
    send_matrix(a);
    // tiny determinant saturates high and low
    a = base; a[0] = 1; a[4] = 1; a[8] = 1;
    send_matrix(a);
    a = base; a[0] = -1; a[4] = 1; a[8] = 1;
    send_matrix(a);
    // permutation with off-diagonal entries
    a = base; a[1] = ONE_Q; a[5] = -ONE_Q; a[6] = ONE_Q;
    send_matrix(a);
    a = base; a[2] = m3i_pkg::ENT_MIN; a[4] = 1; a[6] = m3i_pkg::ENT_MAX;
    send_matrix(a);
    for (int n = 0; n < 5; n++) send_matrix(make_matrix(MK_TINY));
    for (int n = 0; n < 5; n++) send_matrix(make_matrix(MK_FULL));
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    matrix_kind_t kind;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1: kind = MK_FULL;
        2, 3, 4: kind = MK_MODEST;
        5, 6: kind = MK_DIAG;
        7: kind = MK_SINGULAR;
        default: kind = MK_TINY;
      endcase
      send_matrix(make_matrix(kind));
    end
    drain();
  endtask

  // Block the output for a long stretch while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = LONG_HOLD;
    for (int n = 0; n < 80; n++) send_matrix(make_matrix(MK_MODEST));
    drain();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_r0c0 = '0; in_ch.in_r0c1 = '0; in_ch.in_r0c2 = '0;
    in_ch.in_r1c0 = '0; in_ch.in_r1c1 = '0; in_ch.in_r1c2 = '0;
    in_ch.in_r2c0 = '0; in_ch.in_r2c1 = '0; in_ch.in_r2c2 = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(120, 0, 0);
    test_random(110, 55, 0);
    test_random(110, 0, 55);
    test_backpressure();
    test_random(100, 7, 7);
    if (mismatch_count == 0) begin
      $display("[matrix3_inverse_adjugate_top] OK");
    end else begin
      $display("[matrix3_inverse_adjugate_top] ERROR");
    end
    $finish;
  end

  // Drive output ready: a long hold when asked, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict each accepted request
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      expected_inverses.push_back(predict_inverse({in_ch.in_r2c2, in_ch.in_r2c1,
        in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1, in_ch.in_r1c0,
        in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0}));
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    inverse_t got;
    inverse_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.e = {out_ch.out_r2c2, out_ch.out_r2c1, out_ch.out_r2c0,
               out_ch.out_r1c2, out_ch.out_r1c1, out_ch.out_r1c0,
               out_ch.out_r0c2, out_ch.out_r0c1, out_ch.out_r0c0};
      got.sing = out_ch.singular;
      got.ovf = out_ch.overflow;
      if (expected_inverses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_inverses.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            for (int k = 0; k < 9; k++) begin
              if (got.e[k] !== want.e[k])
                $display("entry %0d: expected %h got %h", k, want.e[k], got.e[k]);
            end
            $display("singular exp %b got %b, overflow exp %b got %b",
                     want.sing, got.sing, want.ovf, got.ovf);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[matrix3_inverse_adjugate_top] ERROR");
        $finish;
      end
    end
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/m3i_pkg.sv
rtl/core/m3i_ifs.sv
rtl/core/m3i_front.sv
rtl/core/m3i_div_step.sv
rtl/core/m3i_back.sv
rtl/core/matrix3_inverse_adjugate_top.sv
rtl/core/m3i_checker.sv
sim/matrix3_inverse_adjugate_top_test.sv
